// File: rtl/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

    // Fixed field widths
    localparam int unsigned PAGE_W    = 14;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned REFOUT_W  = 8;
    localparam int unsigned FREE_W    = 15;

    // Defaults for top-level parameters
    localparam int unsigned NUM_PAGES_DEF = 16384;
    localparam int unsigned REF_BITS_DEF  = 8;

    // Config bus
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register index (paddr[2])
    localparam logic REG_LOWEST_PAGE = 1'b0;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEC   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page;
    } in_word_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   page_out;
        logic [STATUS_W-1:0] status;
        logic                released;
        logic [REFOUT_W-1:0] ref_count;
        logic [FREE_W-1:0]   free_pages;
    } out_word_t;

    // Write enables from the update logic
    typedef struct packed {
        logic ref_we;
        logic stk_we;
    } mem_we_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EXEC
    } state_t;

    // Count as shown on the result: saturates at 255
    function automatic logic [REFOUT_W-1:0] show_ref(input logic [31:0] c);
        logic [REFOUT_W-1:0] r;
        r = (c > 32'd255) ? 8'hFF : c[REFOUT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pfa_ram.sv
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port.
module pfa_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 16,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/pfa_exec.sv
`default_nettype none

// Read-modify-write update for one operation: new count, stack push/pop,
// new free count and the result word.
module pfa_exec #(
    parameter  int unsigned NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
    parameter  int unsigned REF_BITS  = pfa_pkg::REF_BITS_DEF,
    localparam int unsigned CNT_W     = $clog2(NUM_PAGES + 1),
    localparam int unsigned PAW       = $clog2(NUM_PAGES)
) (
    input  wire pfa_pkg::in_word_t                  item,
    input  wire logic [pfa_pkg::PAGE_W-1:0]         lowest_page,
    input  wire logic [REF_BITS-1:0]                ref_rd,
    input  wire logic [pfa_pkg::PAGE_W-1:0]         pop_page,
    input  wire logic [CNT_W-1:0]                   free_count,
    output pfa_pkg::mem_we_t                        we,
    output logic      [REF_BITS-1:0]                ref_wdata,
    output logic      [PAW-1:0]                     stk_waddr,
    output logic      [pfa_pkg::PAGE_W-1:0]         stk_wdata,
    output logic      [CNT_W-1:0]                   free_count_next,
    output pfa_pkg::out_word_t                      result
);

    localparam int unsigned         FW      = pfa_pkg::FREE_W;
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    logic                          in_range;
    logic                          pop_in_range;
    logic                          cnt_empty;
    logic                          stk_full;
    logic [REF_BITS-1:0]           ref_inc;
    logic [REF_BITS-1:0]           ref_dec;
    logic [REF_BITS-1:0]           ref_new;
    logic [pfa_pkg::REFOUT_W-1:0]  shown;

    always_comb
    begin
        in_range     = 32'(item.page) < 32'(NUM_PAGES);
        pop_in_range = 32'(pop_page) < 32'(NUM_PAGES);
        cnt_empty    = (free_count == '0);
        stk_full     = 32'(free_count) >= 32'(NUM_PAGES);
        ref_inc      = (ref_rd == REF_MAX) ? ref_rd : ref_rd + 1'b1;
        ref_dec      = (ref_rd == '0) ? ref_rd : ref_rd - 1'b1;
        stk_waddr    = free_count[PAW-1:0];
        stk_wdata    = item.page;
    end

    always_comb
    begin
        we              = '0;
        ref_new         = ref_rd;
        free_count_next = free_count;
        result.page_out = item.page;
        result.status   = pfa_pkg::STATUS_OK;
        result.released = 1'b0;
        result.ref_count = '0;

        unique case (item.mode) inside
            pfa_pkg::MODE_ALLOC:
            begin
                if (cnt_empty)
                begin
                    result.page_out = '0;
                    result.status   = pfa_pkg::STATUS_NO_FREE;
                end
                else
                begin
                    free_count_next = free_count - 1'b1;
                    result.page_out = pop_page;
                    if (pop_in_range)
                    begin
                        ref_new   = ref_inc;
                        we.ref_we = 1'b1;
                    end
                end
            end
            pfa_pkg::MODE_FREE:
            begin
                if (!in_range || (item.page < lowest_page))
                begin
                    result.status = pfa_pkg::STATUS_RANGE;
                end
                else
                begin
                    ref_new   = ref_dec;
                    we.ref_we = 1'b1;
                    // zero count (also a repeated free) goes back on the stack unless it is full
                    if ((ref_dec == '0) && !stk_full)
                    begin
                        we.stk_we       = 1'b1;
                        free_count_next = free_count + 1'b1;
                        result.released = 1'b1;
                    end
                end
            end
            pfa_pkg::MODE_INC, pfa_pkg::MODE_DEC, pfa_pkg::MODE_READ:
            begin
                if (!in_range)
                begin
                    result.status = pfa_pkg::STATUS_RANGE;
                end
                else if (item.mode == pfa_pkg::MODE_INC)
                begin
                    ref_new   = ref_inc;
                    we.ref_we = 1'b1;
                end
                else if (item.mode == pfa_pkg::MODE_DEC)
                begin
                    ref_new   = ref_dec;
                    we.ref_we = 1'b1;
                end
            end
            default:
            begin
                result.page_out = '0;
            end
        endcase

        shown     = pfa_pkg::show_ref(32'(ref_new));
        ref_wdata = ref_new;

        // count shown whenever the page was acted on
        if ((result.status == pfa_pkg::STATUS_OK) &&
            ((item.mode == pfa_pkg::MODE_ALLOC && pop_in_range) ||
             item.mode == pfa_pkg::MODE_FREE || item.mode == pfa_pkg::MODE_INC ||
             item.mode == pfa_pkg::MODE_DEC || item.mode == pfa_pkg::MODE_READ))
        begin
            result.ref_count = shown;
        end

        result.free_pages = FW'(free_count_next);
    end

endmodule

`default_nettype wire

// File: rtl/page_frame_allocator_refcount.sv
// Page-frame allocator with per-page reference counts.
// Input channel (in_valid / in_stall / in_data): one operation word, mode
// and page. A word is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall / out_data): one result word per
// operation, held in an output register until the receiver takes it.
// Steps: free, inc, dec and read are read in IDLE and written back in EXEC;
// alloc goes through POP between them, since the popped page number must
// come out of the stack RAM before its count can be read. One operation is
// in flight at a time, so no new word is taken until the read-then-write-back
// turn of the count RAM is done.
// A finished result may wait in the output register while the next word
// is accepted and read; the update stalls only if the register is still
// full when it is ready to write.
// Reset: a clearing pass zeroes every entry of the count RAM, one entry a
// cycle; in_stall stays high throughout. The free count and lowest_page
// reset to zero. APB writes to lowest_page are taken at any time.
`default_nettype none

module page_frame_allocator_refcount #(
    parameter int unsigned NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
    parameter int unsigned REF_BITS  = pfa_pkg::REF_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // config
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pfa_pkg::APB_AW-1:0]    paddr,
    input  wire logic [pfa_pkg::APB_DW-1:0]    pwdata,
    output logic      [pfa_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    // operation words
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pfa_pkg::in_word_t             in_data,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pfa_pkg::out_word_t                 out_data
);

    localparam int unsigned CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int unsigned PAW    = $clog2(NUM_PAGES);
    localparam int unsigned PAGE_W = pfa_pkg::PAGE_W;

    // control state
    pfa_pkg::state_t          state_reg, state_next;
    logic [PAW-1:0]           clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]         free_count_reg, free_count_next;
    logic [PAGE_W-1:0]        lowest_page_reg, lowest_page_next;
    logic                     out_valid_reg, out_valid_next;

    // payload
    pfa_pkg::in_word_t        item_reg;
    logic [PAW-1:0]           ref_addr_reg;
    pfa_pkg::out_word_t       out_data_reg;

    // RAM ports
    logic                     ref_we, ref_re;
    logic [PAW-1:0]           ref_waddr, ref_raddr;
    logic [REF_BITS-1:0]      ref_wdata, ref_rdata;
    logic                     stk_re;
    logic [PAW-1:0]           stk_raddr, stk_waddr;
    logic [PAGE_W-1:0]        stk_wdata, stk_rdata;

    // update logic
    pfa_pkg::mem_we_t         upd_we;
    logic [REF_BITS-1:0]      upd_ref_wdata;
    logic [CNT_W-1:0]         upd_free_count;
    pfa_pkg::out_word_t       upd_result;

    logic                     accept;
    logic                     exec_go;
    logic                     cfg_wr;
    logic [31:0]              page_ext;
    logic [31:0]              pop_ext;
    logic [CNT_W-1:0]         fc_dec;

    pfa_ram #(
        .WIDTH (REF_BITS),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    pfa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_stk_ram (
        .clk   (clk),
        .we    (upd_we.stk_we && exec_go),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    pfa_exec #(
        .NUM_PAGES (NUM_PAGES),
        .REF_BITS  (REF_BITS)
    ) u_exec (
        .item            (item_reg),
        .lowest_page     (lowest_page_reg),
        .ref_rd          (ref_rdata),
        .pop_page        (stk_rdata),
        .free_count      (free_count_reg),
        .we              (upd_we),
        .ref_wdata       (upd_ref_wdata),
        .stk_waddr       (stk_waddr),
        .stk_wdata       (stk_wdata),
        .free_count_next (upd_free_count),
        .result          (upd_result)
    );

    // ---- handshake and config ----
    assign in_stall  = (state_reg != pfa_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    // update may proceed once the output register is free or being emptied
    assign exec_go   = (state_reg == pfa_pkg::ST_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == pfa_pkg::REG_LOWEST_PAGE);

    always_comb
    begin
        if (paddr[2] == pfa_pkg::REG_LOWEST_PAGE)
        begin
            prdata = 32'(lowest_page_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ---- addresses ----
    assign page_ext = 32'(in_data.page);
    assign pop_ext  = 32'(stk_rdata);
    assign fc_dec   = free_count_reg - 1'b1;

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfa_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == PAW'(NUM_PAGES - 1))
                begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            pfa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.mode == pfa_pkg::MODE_ALLOC) ?
                                 pfa_pkg::ST_POP : pfa_pkg::ST_EXEC;
                end
            end
            pfa_pkg::ST_POP:
            begin
                state_next = pfa_pkg::ST_EXEC;
            end
            pfa_pkg::ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::ST_CLEAR;
            end
        endcase
    end

    // ---- state outputs: RAM control ----
    always_comb
    begin
        ref_re    = 1'b0;
        ref_raddr = page_ext[PAW-1:0];
        stk_re    = 1'b0;
        stk_raddr = fc_dec[PAW-1:0];
        ref_we    = 1'b0;
        ref_waddr = ref_addr_reg;
        ref_wdata = upd_ref_wdata;
        unique case (state_reg)
            pfa_pkg::ST_CLEAR:
            begin
                ref_we    = 1'b1;
                ref_waddr = clr_idx_reg;
                ref_wdata = '0;
            end
            pfa_pkg::ST_IDLE:
            begin
                // top of stack is read for every word; only alloc uses it
                ref_re = in_valid;
                stk_re = in_valid;
            end
            pfa_pkg::ST_POP:
            begin
                ref_re    = 1'b1;
                ref_raddr = pop_ext[PAW-1:0];
            end
            pfa_pkg::ST_EXEC:
            begin
                ref_we = exec_go && upd_we.ref_we;
            end
            default:
            begin
                ref_we = 1'b0;
            end
        endcase
    end

    // ---- register next values ----
    always_comb
    begin
        clr_idx_next     = (state_reg == pfa_pkg::ST_CLEAR) ? clr_idx_reg + 1'b1 : clr_idx_reg;
        free_count_next  = exec_go ? upd_free_count : free_count_reg;
        lowest_page_next = cfg_wr ? pwdata[PAGE_W-1:0] : lowest_page_reg;
        out_valid_next   = exec_go || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pfa_pkg::ST_CLEAR;
            clr_idx_reg     <= '0;
            free_count_reg  <= '0;
            lowest_page_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            free_count_reg  <= free_count_next;
            lowest_page_reg <= lowest_page_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= in_data;
            ref_addr_reg <= page_ext[PAW-1:0];
        end
        else if (state_reg == pfa_pkg::ST_POP)
        begin
            ref_addr_reg <= pop_ext[PAW-1:0];
        end
        if (exec_go)
        begin
            out_data_reg <= upd_result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pfa_checker.sv
`default_nettype none

module pfa_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire pfa_pkg::out_word_t out_data
);

    // held result word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // one operation at a time: busy right after taking a word
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("word accepted while another is in flight");

    // failed alloc only happens with an empty stack
    a_no_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == pfa_pkg::STATUS_NO_FREE) |->
        (out_data.free_pages == '0) && (out_data.page_out == '0))
        else $error("no-free status with pages on the stack");

    // a push is always a successful free and leaves a zero count
    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.released |->
        (out_data.status == pfa_pkg::STATUS_OK) && (out_data.ref_count == '0) &&
        (out_data.free_pages != '0))
        else $error("release with bad status or count");

endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/pfa_tb_pkg.sv
`timescale 1ns / 1ps

package pfa_tb_pkg;

    import pfa_pkg::*;

    localparam int unsigned PAGE_MAX  = NUM_PAGES_DEF - 1;
    localparam int unsigned COUNT_MAX = (1 << REF_BITS_DEF) - 1;

    // Mode codes with no operation behind them
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    class frame_scoreboard;

        bit [REF_BITS_DEF-1:0] ref_counts    [NUM_PAGES_DEF];
        bit [PAGE_W-1:0]       stacked_pages [NUM_PAGES_DEF];
        int unsigned           stack_depth;
        logic [PAGE_W-1:0]     lowest_page;
        out_word_t             awaited_results [$];
        int unsigned           errors;

        function new();
            stack_depth = 0;
            lowest_page = '0;
            errors      = 0;
        endfunction

        function void set_lowest(logic [PAGE_W-1:0] value);
            lowest_page = value;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Apply one accepted operation word and queue the result it must produce.
        function void take_request(in_word_t req);
            out_word_t         res;
            logic [PAGE_W-1:0] pg;
            res = '0;
            res.page_out = req.page;
            case (req.mode)
                MODE_ALLOC:
                begin
                    if (stack_depth == 0)
                    begin
                        res.page_out = '0;
                        res.status   = STATUS_NO_FREE;
                    end
                    else
                    begin
                        stack_depth--;
                        pg = stacked_pages[stack_depth];
                        res.page_out = pg;
                        if (ref_counts[pg] < COUNT_MAX)
                            ref_counts[pg]++;
                        res.ref_count = ref_counts[pg];
                    end
                end
                MODE_FREE:
                begin
                    if (req.page >= NUM_PAGES_DEF || req.page < lowest_page)
                        res.status = STATUS_RANGE;
                    else
                    begin
                        if (ref_counts[req.page] != 0)
                            ref_counts[req.page]--;
                        // no double-free detection; a full stack drops the push
                        if (ref_counts[req.page] == 0 && stack_depth < NUM_PAGES_DEF)
                        begin
                            stacked_pages[stack_depth] = req.page;
                            stack_depth++;
                            res.released = 1'b1;
                        end
                        res.ref_count = ref_counts[req.page];
                    end
                end
                MODE_INC, MODE_DEC, MODE_READ:
                begin
                    if (req.page >= NUM_PAGES_DEF)
                        res.status = STATUS_RANGE;
                    else
                    begin
                        if (req.mode == MODE_INC && ref_counts[req.page] < COUNT_MAX)
                            ref_counts[req.page]++;
                        else if (req.mode == MODE_DEC && ref_counts[req.page] != 0)
                            ref_counts[req.page]--;
                        res.ref_count = ref_counts[req.page];
                    end
                end
                default:
                    res.page_out = '0;
            endcase
            res.free_pages = FREE_W'(stack_depth);
            awaited_results.push_back(res);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none expected: page_out=%0d status=%0d released=%0d ref_count=%0d free_pages=%0d",
                         $time, got.page_out, got.status, got.released, got.ref_count,
                         got.free_pages);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got !== want)
            begin
                $display("%0t: expected page_out=%0d status=%0d released=%0d ref_count=%0d free_pages=%0d",
                         $time, want.page_out, want.status, want.released, want.ref_count,
                         want.free_pages);
                $display("%0t:   actual page_out=%0d status=%0d released=%0d ref_count=%0d free_pages=%0d",
                         $time, got.page_out, got.status, got.released, got.ref_count,
                         got.free_pages);
                errors++;
            end
        endfunction

    endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import pfa_pkg::*;
    import pfa_tb_pkg::*;

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD        = 64;    // long receiver back-pressure stretch
    localparam int RANDOM_PER_PHASE = 160;
    localparam int HOT_SPAN         = 32;    // pages just above lowest_page that see most traffic

    localparam logic [APB_AW-1:0] LOWEST_PAGE_ADDR = {REG_LOWEST_PAGE, 2'b00};
    localparam logic [PAGE_W-1:0] TOP_PAGE         = PAGE_W'(PAGE_MAX);

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    in_word_t          in_data;
    logic              out_valid;
    logic              out_stall;
    out_word_t         out_data;

    frame_scoreboard sb;

    // Shared by both sides: largest per-word idle draw. 0 gives a no-idle stretch.
    int idle_max = 0;
    // Set by the stimulus, consumed by the result sink to start a long stall.
    bit hold_request = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    page_frame_allocator_refcount DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Offer one operation word and hold it until taken. Valid is dropped only when
    // an idle gap is drawn, so back-to-back words never lower and raise valid in
    // the same step.
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] page);
        int       gap;
        in_word_t word;
        gap = $urandom_range(0, idle_max);
        word.mode = mode;
        word.page = page;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= in_word_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_data  <= word;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_request(word);
    endtask

    // Sender pause: nothing offered until every expected result is back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of lowest_page, then a read back of the same register.
    task automatic set_lowest_page(input logic [PAGE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LOWEST_PAGE_ADDR;
        pwdata  <= {{(APB_DW - PAGE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_lowest(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[PAGE_W-1:0] !== value)
        begin
            $display("%0t: lowest_page read back: expected %0d actual %0d",
                     $time, value, prdata[PAGE_W-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Most traffic lands in a small window at lowest_page so pages cycle through
    // the stack; some goes just below it and some anywhere.
    function automatic logic [PAGE_W-1:0] pick_page();
        int pick;
        int offs;
        int pg;
        pick = $urandom_range(0, 99);
        offs = $urandom_range(0, HOT_SPAN - 1);
        if (pick < 80)
        begin
            pg = sb.lowest_page + offs;
            if (pg > PAGE_MAX)
                pg = PAGE_MAX - offs;
        end
        else if (pick < 90)
            pg = (sb.lowest_page == 0) ? 0 : sb.lowest_page - 1;
        else
            pg = $urandom_range(0, PAGE_MAX);
        return pg[PAGE_W-1:0];
    endfunction

    task automatic random_ops(input int count);
        int                k;
        int                pick;
        logic [MODE_W-1:0] mode;
        for (k = 0; k < count; k++)
        begin
            // switch idling on or off every hundred words
            if (k % 100 == 0)
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            pick = $urandom_range(0, 99);
            if (pick < 25)
                mode = MODE_ALLOC;
            else if (pick < 50)
                mode = MODE_FREE;
            else if (pick < 64)
                mode = MODE_INC;
            else if (pick < 78)
                mode = MODE_DEC;
            else if (pick < 95)
                mode = MODE_READ;
            else
                mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            send_op(mode, pick_page());
        end
    endtask

    // Result sink: checks each taken word, then stalls for a drawn number of
    // cycles. A hold request overrides that with one long stall.
    initial
    begin : result_sink
        int gap;
        int long_left;
        gap       = 0;
        long_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_data);
                gap = $urandom_range(0, idle_max);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                long_left    = LONG_HOLD;
            end
            if (long_left > 0)
            begin
                out_stall <= 1'b1;
                long_left--;
            end
            else if (gap > 0)
            begin
                out_stall <= 1'b1;
                gap--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int                k;
        int                phase;
        logic [PAGE_W-1:0] low;
        sb = new();
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // block is still clearing its count table; stall holds off the first word
        set_lowest_page('0);

        // ---- directed: edges of each operation ----
        idle_max = 5;
        send_op(MODE_ALLOC, TOP_PAGE);          // empty stack -> no free page
        send_op(MODE_READ, '0);
        send_op(MODE_READ, TOP_PAGE);
        send_op(MODE_DEC, 14'd5);               // dec at zero stays zero
        send_op(MODE_FREE, TOP_PAGE);           // free at zero pushes
        send_op(MODE_FREE, '0);
        send_op(MODE_ALLOC, 14'h1555);          // pops page 0, page field ignored
        send_op(MODE_INC, '0);
        send_op(MODE_FREE, '0);                 // count 2 -> 1, not released
        for (k = MODE_SPARE_FIRST; k <= MODE_SPARE_LAST; k++)
            send_op(k[MODE_W-1:0], 14'h2AAA);   // unused modes touch nothing
        // walk the top page to the count limit and one past it
        for (k = 0; k <= COUNT_MAX; k++)
            send_op(MODE_INC, TOP_PAGE);
        send_op(MODE_ALLOC, '0);                // pops the page at max count
        send_op(MODE_DEC, TOP_PAGE);
        wait_idle();

        // free range checks at the top setting; inc/read ignore it
        set_lowest_page(TOP_PAGE);
        send_op(MODE_FREE, '0);
        send_op(MODE_FREE, TOP_PAGE - 1'b1);
        send_op(MODE_FREE, TOP_PAGE);
        send_op(MODE_INC, '0);
        send_op(MODE_READ, '0);
        wait_idle();
        set_lowest_page('0);

        // ---- random phases, each with its own lowest_page ----
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       low = PAGE_W'($urandom_range(1, PAGE_MAX - 1));
                1:       low = '0;
                2:       low = TOP_PAGE;
                default: low = PAGE_W'($urandom_range(0, 63));
            endcase
            set_lowest_page(low);
            // long stall while words keep coming: the block fills and stalls input
            if (phase == 1)
                hold_request = 1'b1;
            random_ops(RANDOM_PER_PHASE);
            wait_idle();
        end

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
